### hw/rtl/sgm_pkg.sv
// Shared types and constants of the Sobel gradient magnitude block.
`default_nettype none

package sgm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W     = 8;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int ROW_CNT_W = 13;
    localparam int COL_CNT_W = 11;

    localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RESET = ROW_CNT_W'(480);
    localparam logic [COL_CNT_W-1:0] COL_COUNT_RESET = COL_CNT_W'(640);

    // job queue between front and back
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // gradient datapath
    localparam int GRAD_W     = 12;                 // signed axis sum before clamp
    localparam int AXIS_W     = 11;                 // signed axis sum after clamp
    localparam int SUM_W      = 21;                 // gx^2 + gy^2
    localparam int ROOT_W     = 9;                  // root bits kept below saturation
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    localparam logic [PIX_W-1:0]  GRAD_MAX  = PIX_W'(255);
    localparam logic signed [GRAD_W-1:0] AXIS_CLAMP = GRAD_W'(255);
    // isqrt(v)/2 reaches 255 exactly when v >= 510*510
    localparam logic [SUM_W-1:0]  SAT_LIMIT = SUM_W'(260100);

    typedef logic [PIX_W-1:0] t_pix;

    // 3x3 window, entry row*3+col, row 0 top, col 0 left
    typedef struct packed {
        t_pix [8:0]       win;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_job;

    // frame geometry as seen by the front end
    typedef struct packed {
        logic [ROW_W-1:0] nr_m1;
        logic [COL_W-1:0] nc_m1;
        logic             restart;
    } t_frame_cfg;

endpackage

`default_nettype wire

### hw/rtl/sgm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module sgm_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hw/rtl/sgm_front.sv
// Front end: pixel intake, line stores, window and job generation.
`default_nettype none

module sgm_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire sgm_pkg::t_frame_cfg       i_cfg,
    input  wire logic                      i_push,
    output logic                           o_full,
    input  wire logic [sgm_pkg::PIX_W-1:0] i_pixel,
    output logic                           o_job_push,
    output sgm_pkg::t_job                  o_job,
    input  wire logic                      i_job_full
);
    import sgm_pkg::*;

    localparam logic [1:0] SRC_OLDER = 2'd0;
    localparam logic [1:0] SRC_PREV  = 2'd1;
    localparam logic [1:0] SRC_CUR   = 2'd2;

    // position of the next pixel
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;

    // stage B: pixel whose line store data is on the RAM outputs
    logic             r_b_valid;
    t_pix             r_b_pix;
    logic [ROW_W-1:0] r_b_row;
    logic [COL_W-1:0] r_b_col;
    logic [3:0]       r_mask;     // pending jobs: bit0/1 upper row, bit2/3 bottom row
    t_pix [2:0]       r_win_a;    // column c-2, per source row
    t_pix [2:0]       r_win_b;    // column c-1

    t_pix             older_rd;
    t_pix             prev_rd;
    t_pix [2:0]       cn;
    t_pix [2:0]       col_l;
    t_pix [2:0]       col_m;
    t_pix [2:0]       col_r;
    logic [1:0]       rs_src [3];
    logic [1:0]       sel;
    logic [3:0]       rest;
    logic [3:0]       n_mask;
    logic             accept;
    logic             b_done;
    logic             has_col;
    logic             has_row;
    logic             end_col;
    logic             end_row;

    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (b_done),
        .i_wr_addr (r_b_col),
        .i_wr_data (r_b_pix),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (prev_rd)
    );

    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
        .i_clk     (i_clk),
        .i_wr_en   (b_done),
        .i_wr_addr (r_b_col),
        .i_wr_data (prev_rd),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (older_rd)
    );

    always_comb begin
        cn   = {r_b_pix, prev_rd, older_rd};
        rest = r_mask & (r_mask - 4'd1);

        priority if (r_mask[0]) begin
            sel = 2'd0;
        end else if (r_mask[1]) begin
            sel = 2'd1;
        end else if (r_mask[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end

        o_job_push = r_b_valid && (r_mask != 4'd0) && !i_job_full;
        b_done     = r_b_valid && ((r_mask == 4'd0) || ((rest == 4'd0) && !i_job_full));
        o_full     = r_b_valid && !b_done;
        accept     = i_push && !o_full;

        // sel[0]: second result of a row end, mirrored right border
        if (!sel[0]) begin
            col_l = (r_b_col == COL_W'(1)) ? cn : r_win_a;
            col_m = r_win_b;
            col_r = cn;
        end else begin
            col_l = r_win_b;
            col_m = cn;
            col_r = r_win_b;
        end

        // sel[1]: bottom row, mirrored lower border
        if (!sel[1]) begin
            rs_src[0] = (r_b_row == ROW_W'(1)) ? SRC_CUR : SRC_OLDER;
            rs_src[1] = SRC_PREV;
            rs_src[2] = SRC_CUR;
        end else begin
            rs_src[0] = SRC_PREV;
            rs_src[1] = SRC_CUR;
            rs_src[2] = SRC_PREV;
        end

        for (int i = 0; i < 3; i++) begin
            o_job.win[i*3+0] = col_l[rs_src[i]];
            o_job.win[i*3+1] = col_m[rs_src[i]];
            o_job.win[i*3+2] = col_r[rs_src[i]];
        end
        o_job.row  = sel[1] ? r_b_row : r_b_row - ROW_W'(1);
        o_job.col  = sel[0] ? r_b_col : r_b_col - COL_W'(1);
        o_job.last = sel[1] && sel[0];

        has_col = r_col != '0;
        has_row = r_row != '0;
        end_col = r_col == i_cfg.nc_m1;
        end_row = r_row == i_cfg.nr_m1;
        n_mask  = {has_col && end_row && end_col, has_col && end_row,
                   has_col && has_row && end_col, has_col && has_row};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_b_valid <= 1'b0;
            r_mask    <= '0;
            r_win_a   <= '0;
            r_win_b   <= '0;
        end else begin
            if (i_cfg.restart) begin
                r_row <= '0;
                r_col <= '0;
            end else if (accept) begin
                if (end_col) begin
                    r_col <= '0;
                    r_row <= end_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end

            if (accept) begin
                r_b_valid <= 1'b1;
                r_mask    <= n_mask;
            end else begin
                if (b_done) begin
                    r_b_valid <= 1'b0;
                end
                if (o_job_push) begin
                    r_mask <= rest;
                end
            end

            if (i_cfg.restart) begin
                r_win_a <= '0;
                r_win_b <= '0;
            end else if (b_done) begin
                r_win_a <= r_win_b;
                r_win_b <= cn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix <= i_pixel;
            r_b_row <= r_row;
            r_b_col <= r_col;
        end
    end

    a_mask_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_b_valid |-> (r_mask == 4'd0))
        else $error("pending jobs without a pixel in stage B");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= i_cfg.nc_m1)
        else $error("column counter beyond row length");

endmodule

`default_nettype wire

### hw/rtl/sgm_queue.sv
// Short job queue between front and back end.
`default_nettype none

module sgm_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sgm_pkg::t_job i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output sgm_pkg::t_job      o_data,
    output logic               o_empty
);
    import sgm_pkg::*;

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr;
    logic [JOB_PTR_W-1:0] r_rd_ptr;
    logic [JOB_CNT_W-1:0] r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = r_count == JOB_CNT_W'(JOB_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // depth is a power of two, pointers wrap on their own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + JOB_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + JOB_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + JOB_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - JOB_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= JOB_CNT_W'(JOB_DEPTH))
        else $error("job queue count overflow");

endmodule

`default_nettype wire

### hw/rtl/sgm_back.sv
// Back end: Sobel sums, squared magnitude, bit-serial root and result register.
`default_nettype none

module sgm_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sgm_pkg::t_job              i_job,
    input  wire logic                       i_job_empty,
    output logic                            o_job_pop,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output logic [sgm_pkg::PIX_W-1:0]       o_gradient,
    output logic [sgm_pkg::ROW_W-1:0]       o_out_row,
    output logic [sgm_pkg::COL_W-1:0]       o_out_col,
    output logic                            o_last
);
    import sgm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GRAD,
        S_SQR,
        S_ROOT,
        S_DONE
    } t_state;

    t_state                    r_state;
    t_pix [8:0]                r_win;
    logic [ROW_W-1:0]          r_row;
    logic [COL_W-1:0]          r_col;
    logic                      r_last;
    logic signed [AXIS_W-1:0]  r_gx;
    logic signed [AXIS_W-1:0]  r_gy;
    logic                      r_sat;
    logic [RAD_W-1:0]          r_rad;
    logic [REM_W-1:0]          r_rem;
    logic [ROOT_W-1:0]         r_root;
    logic [STEP_W-1:0]         r_step;
    logic                      r_out_valid;
    logic [PIX_W-1:0]          r_out_grad;
    logic [ROW_W-1:0]          r_out_row;
    logic [COL_W-1:0]          r_out_col;
    logic                      r_out_last;

    logic signed [GRAD_W-1:0]  p [9];
    logic signed [GRAD_W-1:0]  gx_full;
    logic signed [GRAD_W-1:0]  gy_full;
    logic signed [GRAD_W-1:0]  gx_clamp;
    logic signed [GRAD_W-1:0]  gy_clamp;
    logic signed [2*AXIS_W-1:0] sq_x;
    logic signed [2*AXIS_W-1:0] sq_y;
    logic [SUM_W-1:0]          sum_sq;
    logic [REM_W+1:0]          rem_sh;
    logic [REM_W+1:0]          trial;
    logic [REM_W+1:0]          rem_diff;
    logic                      ge;
    logic                      out_free;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            p[k] = signed'({{(GRAD_W-PIX_W){1'b0}}, r_win[k]});
        end
        // right column minus left, bottom row minus top, weights 1 2 1
        gx_full = (p[2] - p[0]) + ((p[5] - p[3]) <<< 1) + (p[8] - p[6]);
        gy_full = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
        gx_clamp = (gx_full > AXIS_CLAMP) ? AXIS_CLAMP : gx_full;
        gy_clamp = (gy_full > AXIS_CLAMP) ? AXIS_CLAMP : gy_full;

        sq_x   = r_gx * r_gx;
        sq_y   = r_gy * r_gy;
        sum_sq = sq_x[SUM_W-1:0] + sq_y[SUM_W-1:0];

        // one root bit per step
        rem_sh   = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial    = {{(REM_W-ROOT_W){1'b0}}, r_root, 2'b01};
        ge       = rem_sh >= trial;
        rem_diff = rem_sh - trial;

        out_free  = !r_out_valid || i_pop;
        o_job_pop = (r_state == S_IDLE) && !i_job_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_win   <= i_job.win;
                        r_row   <= i_job.row;
                        r_col   <= i_job.col;
                        r_last  <= i_job.last;
                        r_state <= S_GRAD;
                    end
                end
                S_GRAD: begin
                    r_gx    <= gx_clamp[AXIS_W-1:0];
                    r_gy    <= gy_clamp[AXIS_W-1:0];
                    r_state <= S_SQR;
                end
                S_SQR: begin
                    r_sat   <= sum_sq >= SAT_LIMIT;
                    r_rad   <= sum_sq[RAD_W-1:0];
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_step  <= STEP_W'(ROOT_STEPS - 1);
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_rem  <= ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                    r_root <= {r_root[ROOT_W-2:0], ge};
                    r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                    if (r_step == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_grad  <= r_sat ? GRAD_MAX : r_root[ROOT_W-1:1];
                        r_out_row   <= r_row;
                        r_out_col   <= r_col;
                        r_out_last  <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_gradient = r_out_grad;
    assign o_out_row  = r_out_row;
    assign o_out_col  = r_out_col;
    assign o_last     = r_out_last;

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> (r_step <= STEP_W'(ROOT_STEPS - 1)))
        else $error("root step counter out of range");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> ({1'b0, r_rem} <= {2'b00, r_root, 1'b0}))
        else $error("root remainder exceeds twice the partial root");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result register loaded outside the hand-off state");

endmodule

`default_nettype wire

### hw/rtl/sobel_gradient_magnitude.sv
// Top level of the streaming 3x3 Sobel gradient magnitude block.
//
//  channel   dir  handshake                  payload
//  -------   ---  -------------------------  -----------------------------------
//  pixels    in   push / full                i_pixel
//  results   out  pop / empty                o_gradient o_out_row o_out_col o_last
//  config    in   APB psel penable pwrite    paddr pwdata -> prdata (pready high)
//
// A pixel that yields no result never holds up the intake; the front end takes the
// next pixel as soon as it has queued the jobs of the current one.
// The back end works on one result at a time, in order: queue pop, axis sums, squares,
// nine steps of the bit-serial root, hand-off to the result register.
// A row end adds one result, the last row doubles them: up to four per pixel.
// Reset is synchronous; line stores are not cleared and need no clearing pass.
// A full job queue stalls the front end, a held result stalls the back end.
`default_nettype none

module sobel_gradient_magnitude (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    // pixels
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [sgm_pkg::PIX_W-1:0]  i_pixel,
    // results
    output logic                            empty,
    input  wire logic                       pop,
    output logic [sgm_pkg::PIX_W-1:0]       o_gradient,
    output logic [sgm_pkg::ROW_W-1:0]       o_out_row,
    output logic [sgm_pkg::COL_W-1:0]       o_out_col,
    output logic                            o_last
);
    import sgm_pkg::*;

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    logic [ROW_CNT_W-1:0] r_row_count;
    logic [COL_CNT_W-1:0] r_col_count;
    logic                 cfg_wr;
    logic                 reg_idx;
    logic [ROW_CNT_W-1:0] row_m1;
    logic [COL_CNT_W-1:0] col_m1;
    t_frame_cfg           frame_cfg;

    t_job                 job_in;
    t_job                 job_out;
    logic                 job_push;
    logic                 job_full;
    logic                 job_pop;
    logic                 job_empty;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RESET;
            r_col_count <= COL_COUNT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ROW_COUNT: r_row_count <= pwdata[ROW_CNT_W-1:0];
                REG_COL_COUNT: r_col_count <= pwdata[COL_CNT_W-1:0];
                default:       r_row_count <= r_row_count;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROW_COUNT: prdata = 32'(r_row_count);
            REG_COL_COUNT: prdata = 32'(r_col_count);
            default:       prdata = '0;
        endcase

        // sizes clamped to [2, max], kept as size minus one
        row_m1 = r_row_count - ROW_CNT_W'(1);
        col_m1 = r_col_count - COL_CNT_W'(1);
        if (r_row_count < ROW_CNT_W'(2)) begin
            frame_cfg.nr_m1 = ROW_W'(1);
        end else if (r_row_count > ROW_CNT_W'(MAX_HEIGHT)) begin
            frame_cfg.nr_m1 = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            frame_cfg.nr_m1 = row_m1[ROW_W-1:0];
        end
        if (r_col_count < COL_CNT_W'(2)) begin
            frame_cfg.nc_m1 = COL_W'(1);
        end else if (r_col_count > COL_CNT_W'(MAX_WIDTH)) begin
            frame_cfg.nc_m1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            frame_cfg.nc_m1 = col_m1[COL_W-1:0];
        end
        // any size write restarts the frame
        frame_cfg.restart = cfg_wr;
    end

    sgm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (frame_cfg),
        .i_push     (push),
        .o_full     (full),
        .i_pixel    (i_pixel),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    sgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    sgm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_gradient  (o_gradient),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

### tb/tb_sobel_gradient_magnitude.sv
// Self-checking testbench for the Sobel gradient block: directed, size extremes, random frames.
module tb_sobel_gradient_magnitude;
    import sgm_pkg::*;

    localparam int REG_ROW_COUNT  = 0;
    localparam int REG_COL_COUNT  = 1;
    localparam int CYCLE_LIMIT    = 200_000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int NO_GRAD        = -1;
    localparam int RANDOM_PIXELS  = 50;
    localparam int EXTREME_PIXELS = 12;
    localparam int MAX_PRINTS     = 50;

    localparam int KX [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    localparam int KY [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

    typedef enum logic [1:0] {STEP_PIXEL, STEP_SET_ROWS, STEP_SET_COLS} t_step_kind;

    typedef struct packed {
        t_step_kind  kind;
        logic [15:0] value;
        int          grad;      // typed gradient for every result of the pixel, or NO_GRAD
    } t_step;

    typedef struct packed {
        logic [PIX_W-1:0] grad;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_gradient;

    // one window column: 0 older row, 1 previous row, 2 current row
    typedef logic [2:0][PIX_W-1:0] t_column;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [2:0]        paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              push    = 1'b0;
    logic              full;
    logic [PIX_W-1:0]  i_pixel = '0;
    logic              empty;
    logic              pop     = 1'b0;
    logic [PIX_W-1:0]  o_gradient;
    logic [ROW_W-1:0]  o_out_row;
    logic [COL_W-1:0]  o_out_col;
    logic              o_last;

    sobel_gradient_magnitude uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .full       (full),
        .i_pixel    (i_pixel),
        .empty      (empty),
        .pop        (pop),
        .o_gradient (o_gradient),
        .o_out_row  (o_out_row),
        .o_out_col  (o_out_col),
        .o_last     (o_last)
    );

    // predictor state
    logic [ROW_CNT_W-1:0] row_count_reg;
    logic [COL_CNT_W-1:0] col_count_reg;
    logic [PIX_W-1:0]     prev_line  [MAX_WIDTH];
    logic [PIX_W-1:0]     older_line [MAX_WIDTH];
    t_column              win_left;     // column c-2
    t_column              win_mid;      // column c-1
    int                   frame_row;
    int                   frame_col;

    t_gradient pending_gradients [$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        want_grad      = NO_GRAD;
    bit        send_quiet     = 1'b0;
    bit        pop_quiet      = 1'b0;
    int        pop_hold       = 0;
    int        pop_roll;

    t_step directed_steps [30] = '{
        '{STEP_SET_ROWS, 16'd2, NO_GRAD}, '{STEP_SET_COLS, 16'd2, NO_GRAD},
        '{STEP_PIXEL, 16'd0, NO_GRAD},    '{STEP_PIXEL, 16'd255, NO_GRAD},
        '{STEP_PIXEL, 16'd255, NO_GRAD},  '{STEP_PIXEL, 16'd0, NO_GRAD},
        // flat frame: no gradient anywhere
        '{STEP_SET_COLS, 16'd3, NO_GRAD},
        '{STEP_PIXEL, 16'd255, 0}, '{STEP_PIXEL, 16'd255, 0}, '{STEP_PIXEL, 16'd255, 0},
        '{STEP_PIXEL, 16'd255, 0}, '{STEP_PIXEL, 16'd255, 0}, '{STEP_PIXEL, 16'd255, 0},
        // falling ramp across the row: large negative gx
        '{STEP_SET_ROWS, 16'd3, NO_GRAD},
        '{STEP_PIXEL, 16'd255, NO_GRAD}, '{STEP_PIXEL, 16'd128, NO_GRAD},
        '{STEP_PIXEL, 16'd0, NO_GRAD},   '{STEP_PIXEL, 16'd255, NO_GRAD},
        '{STEP_PIXEL, 16'd128, NO_GRAD}, '{STEP_PIXEL, 16'd0, NO_GRAD},
        '{STEP_PIXEL, 16'd255, NO_GRAD}, '{STEP_PIXEL, 16'd128, NO_GRAD},
        '{STEP_PIXEL, 16'd0, NO_GRAD},
        // rising ramp down the column: gy clamped
        '{STEP_SET_COLS, 16'd2, NO_GRAD},
        '{STEP_PIXEL, 16'd0, NO_GRAD},   '{STEP_PIXEL, 16'd0, NO_GRAD},
        '{STEP_PIXEL, 16'd128, NO_GRAD}, '{STEP_PIXEL, 16'd128, NO_GRAD},
        '{STEP_PIXEL, 16'd255, NO_GRAD}, '{STEP_PIXEL, 16'd255, NO_GRAD}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int row, input int col,
                                   input int got, input int exp_val);
        if (mismatch_count < MAX_PRINTS)
            $display("MISMATCH %s at row %0d col %0d: got %0d, expected %0d",
                     what, row, col, got, exp_val);
        mismatch_count++;
    endtask

    function automatic int eff_rows();
        int n = row_count_reg;
        if (n < 2) n = 2;
        if (n > MAX_HEIGHT) n = MAX_HEIGHT;
        return n;
    endfunction

    function automatic int eff_cols();
        int n = col_count_reg;
        if (n < 2) n = 2;
        if (n > MAX_WIDTH) n = MAX_WIDTH;
        return n;
    endfunction

    // w entry row*3+col, row 0 top
    function automatic logic [PIX_W-1:0] sobel_gradient(input logic [8:0][PIX_W-1:0] w);
        int gx = 0;
        int gy = 0;
        int sq;
        int root = 0;
        int trial;
        for (int i = 0; i < 9; i++) begin
            gx += KX[i] * int'(w[i]);
            gy += KY[i] * int'(w[i]);
        end
        if (gx > 255) gx = 255;
        if (gy > 255) gy = 255;
        sq = gx * gx + gy * gy;
        for (int b = 11; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= sq) root = trial;
        end
        root = root / 2;
        return (root > 255) ? GRAD_MAX : PIX_W'(root);
    endfunction

    task automatic queue_gradient(input t_column lft, input t_column mid, input t_column rgt,
                                  input int s_top, input int s_mid, input int s_bot,
                                  input int orow, input int ocol, input bit last_px,
                                  input int grad);
        logic [8:0][PIX_W-1:0] w;
        t_gradient g;
        w[0] = lft[s_top]; w[1] = mid[s_top]; w[2] = rgt[s_top];
        w[3] = lft[s_mid]; w[4] = mid[s_mid]; w[5] = rgt[s_mid];
        w[6] = lft[s_bot]; w[7] = mid[s_bot]; w[8] = rgt[s_bot];
        g.grad = (grad == NO_GRAD) ? sobel_gradient(w) : PIX_W'(grad);
        g.row  = ROW_W'(orow);
        g.col  = COL_W'(ocol);
        g.last = last_px;
        pending_gradients.push_back(g);
    endtask

    // results of one output row for the column just completed; a row end adds its own
    task automatic queue_row(input t_column ca, input t_column cb, input t_column cn,
                             input int s_top, input int s_mid, input int s_bot,
                             input int c, input int nc, input int orow,
                             input bit last_row, input int grad);
        queue_gradient((c == 1) ? cn : ca, cb, cn, s_top, s_mid, s_bot,
                       orow, c - 1, 1'b0, grad);
        if (c == nc - 1)
            queue_gradient(cb, cn, cb, s_top, s_mid, s_bot, orow, c, last_row, grad);
    endtask

    task automatic advance_pixel(input logic [PIX_W-1:0] pix, input int grad);
        int nr;
        int nc;
        int r;
        int c;
        t_column ca;
        t_column cb;
        t_column cn;
        nr = eff_rows();
        nc = eff_cols();
        r  = frame_row;
        c  = frame_col;
        if (c >= nc || r >= nr) begin
            r = 0;
            c = 0;
        end
        c = c & (MAX_WIDTH - 1);
        cn[0] = older_line[c];
        cn[1] = prev_line[c];
        cn[2] = pix;
        ca = win_left;
        cb = win_mid;
        older_line[c] = cn[1];
        prev_line[c]  = cn[2];
        // top row mirrors onto the current row; bottom row mirrors onto the row above
        if (c >= 1 && r >= 1)
            queue_row(ca, cb, cn, (r == 1) ? 2 : 0, 1, 2, c, nc, r - 1, 1'b0, grad);
        if (c >= 1 && r == nr - 1)
            queue_row(ca, cb, cn, 1, 2, 1, c, nc, r, 1'b1, grad);
        win_left = cb;
        win_mid  = cn;
        c++;
        if (c >= nc) begin
            c = 0;
            r++;
            if (r >= nr) r = 0;
        end
        frame_row = r;
        frame_col = c;
    endtask

    task automatic check_gradient();
        t_gradient want;
        if (pending_gradients.size() == 0) begin
            report_mismatch("unexpected result", o_out_row, o_out_col, o_gradient, 0);
            return;
        end
        want = pending_gradients.pop_front();
        if (o_gradient !== want.grad)
            report_mismatch("gradient", want.row, want.col, o_gradient, want.grad);
        if (o_out_row !== want.row)
            report_mismatch("out_row", want.row, want.col, o_out_row, want.row);
        if (o_out_col !== want.col)
            report_mismatch("out_col", want.row, want.col, o_out_col, want.col);
        if (o_last !== want.last)
            report_mismatch("last", want.row, want.col, o_last, want.last);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) advance_pixel(i_pixel, want_grad);
            if (pop && !empty) check_gradient();
        end
    end

    // result side: random stalls, mostly short, with quiet stretches
    always @(negedge i_clk) begin
        if ($urandom_range(0, 299) == 0) pop_quiet = !pop_quiet;
        if (pop_hold > 0) begin
            pop_hold--;
            pop <= 1'b0;
        end else begin
            pop_roll = $urandom_range(0, 99);
            if (pop_quiet || pop_roll >= 30) begin
                pop <= 1'b1;
            end else begin
                pop <= 1'b0;
                pop_hold = (pop_roll < 4) ? $urandom_range(10, 40) : $urandom_range(0, 2);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        if (send_quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // entered and left at a falling edge
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input int grad);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push      <= 1'b1;
        i_pixel   <= pix;
        want_grad <= grad;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic stream_pixels(input int n);
        repeat (n) send_pixel(PIX_W'($urandom_range(0, 255)), NO_GRAD);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_gradients.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] reg_mask(input int index);
        return (index == REG_ROW_COUNT) ? 32'((1 << ROW_CNT_W) - 1)
                                        : 32'((1 << COL_CNT_W) - 1);
    endfunction

    task automatic apb_read_check(input int index, input logic [31:0] exp_val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 3'(4 * index);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== exp_val) report_mismatch("register read", index, 0, prdata, exp_val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // a write restarts the frame; upper data bits are noise
    task automatic write_and_check(input int index, input int value);
        logic [31:0] masked;
        masked = 32'(value) & reg_mask(index);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * index);
        pwdata  <= (32'($urandom) & ~reg_mask(index)) | masked;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (index == REG_ROW_COUNT) row_count_reg = ROW_CNT_W'(masked);
        else col_count_reg = COL_CNT_W'(masked);
        frame_row = 0;
        frame_col = 0;
        win_left  = '0;
        win_mid   = '0;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        apb_read_check(index, masked);
    endtask

    initial begin
        int items;
        int roll;
        int count;
        row_count_reg = ROW_COUNT_RESET;
        col_count_reg = COL_COUNT_RESET;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            prev_line[i]  = '0;
            older_line[i] = '0;
        end
        win_left  = '0;
        win_mid   = '0;
        frame_row = 0;
        frame_col = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        apb_read_check(REG_ROW_COUNT, 32'd480);
        apb_read_check(REG_COL_COUNT, 32'd640);

        foreach (directed_steps[i]) begin
            case (directed_steps[i].kind)
                STEP_SET_ROWS: write_and_check(REG_ROW_COUNT, directed_steps[i].value);
                STEP_SET_COLS: write_and_check(REG_COL_COUNT, directed_steps[i].value);
                default: send_pixel(directed_steps[i].value[PIX_W-1:0], directed_steps[i].grad);
            endcase
        end

        // size extremes: all-ones clamps down, zero and one clamp up
        write_and_check(REG_ROW_COUNT, 8191);
        write_and_check(REG_COL_COUNT, 1);
        stream_pixels(EXTREME_PIXELS);
        write_and_check(REG_ROW_COUNT, 0);
        stream_pixels(eff_rows() * eff_cols());
        write_and_check(REG_COL_COUNT, 2047);
        stream_pixels(EXTREME_PIXELS);

        items = 0;
        while (items < RANDOM_PIXELS) begin
            send_quiet = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 9);
            if (roll != 0)
                write_and_check(REG_ROW_COUNT, $urandom_range(0, 6));
            if (roll != 1)
                write_and_check(REG_COL_COUNT, ($urandom_range(0, 9) == 0) ?
                                $urandom_range(8, 40) : $urandom_range(0, 7));
            count = eff_rows() * eff_cols();
            roll = $urandom_range(0, 99);
            if (roll < 15) count = $urandom_range(1, count - 1);      // cut short
            else if (roll < 30) count += $urandom_range(1, 2 * eff_cols()); // run into next frame
            if (count > RANDOM_PIXELS - items) count = RANDOM_PIXELS - items;
            stream_pixels(count);
            items += count;
        end

        wait_idle();
        if (mismatch_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
